// ----- sv/assert_macros.svh -----
// Assertion macros shared by the scheduler modules.
// Assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- sv/rrts_pkg.sv -----
// Types and constants of the round-robin tick scheduler.
// No dependencies.
package rrts_pkg;
  localparam int unsigned TimeW = 23;
  localparam int unsigned SumW  = 29;
  localparam int unsigned ValW  = 16;
  localparam int unsigned IdxOutW = 6;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};
  localparam logic [7:0] QuantumReset = 8'd2;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef enum logic [2:0] {
    CmdNone, CmdLoad, CmdHead, CmdScanRd, CmdScanCmp, CmdDispatch, CmdFinish, CmdHold
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic scan_first;
  } ctrl_t;

  typedef struct packed {
    logic finished;
    logic scan_last;
    logic load_full;
  } stat_t;
endpackage

// ----- sv/rrts_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rrts_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- sv/rrts_datapath.sv -----
// Datapath of the scheduler: task tables, ready FIFO, counters.
// Depends on rrts_pkg, rrts_ram and assert_macros.svh.
module rrts_datapath #(
  parameter int unsigned MaxTasks = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrts_pkg::ctrl_t    ctrl_i,
  output rrts_pkg::stat_t    stat_o,
  input  logic [15:0]        arrival_i,
  input  logic [15:0]        duration_i,
  input  logic [7:0]         quantum_i,
  output logic [22:0]        slot_time_o,
  output logic               running_valid_o,
  output logic [5:0]         running_index_o,
  output logic               completed_valid_o,
  output logic [5:0]         completed_index_o,
  output logic [22:0]        switch_count_o,
  output logic [28:0]        total_turnaround_o
);
  import rrts_pkg::*;
  localparam int unsigned IW = $clog2(MaxTasks);
  localparam int unsigned CW = $clog2(MaxTasks + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxTasks);
  localparam logic [IW-1:0] IdxLast = IW'(MaxTasks - 1);

  logic [CW-1:0] task_cnt_q, task_cnt_d, fifo_cnt_q, fifo_cnt_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, act_q, act_d, scan_q, scan_d, cmp_idx_q;
  logic act_v_q, act_v_d;
  logic [7:0] slice_q, slice_d;
  logic [TimeW-1:0] time_q, time_d, sw_q, sw_d;
  logic [TimeW-1:0] slot_q, slot_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [16:0] lend_q, lend_d;
  logic done_v_q, done_v_d;
  logic [IW-1:0] done_i_q, done_i_d;

  // memories
  logic arr_we, rem_we, fifo_we;
  logic [IW-1:0] arr_wa, arr_ra, rem_wa, rem_ra, fifo_wa, fifo_ra;
  logic [ValW-1:0] arr_wd, arr_rd, rem_wd, rem_rd;
  logic [IW-1:0] fifo_wd, fifo_rd;

  rrts_ram #(.Width(ValW), .Depth(MaxTasks)) u_arr (
    .clk_i, .we_i(arr_we), .waddr_i(arr_wa), .wdata_i(arr_wd),
    .raddr_i(arr_ra), .rdata_o(arr_rd));
  rrts_ram #(.Width(ValW), .Depth(MaxTasks)) u_rem (
    .clk_i, .we_i(rem_we), .waddr_i(rem_wa), .wdata_i(rem_wd),
    .raddr_i(rem_ra), .rdata_o(rem_rd));
  rrts_ram #(.Width(IW), .Depth(MaxTasks)) u_fifo (
    .clk_i, .we_i(fifo_we), .waddr_i(fifo_wa), .wdata_i(fifo_wd),
    .raddr_i(fifo_ra), .rdata_o(fifo_rd));

  logic [7:0] q_eff;
  logic [16:0] end_sum;
  logic [TimeW-1:0] ta;
  logic [SumW:0] sum_add;
  logic push_ok;
  logic fin;

  assign q_eff = (quantum_i == 8'd0) ? 8'd1 : quantum_i;
  assign end_sum = {1'b0, arrival_i} + {1'b0, duration_i};
  assign ta = (time_q < TimeW'(arr_rd)) ? '0 : time_q - TimeW'(arr_rd);
  assign sum_add = {1'b0, sum_q} + (SumW+1)'(ta);
  assign push_ok = (fifo_cnt_q < CntMax);
  assign fin = !(time_q < TimeW'(lend_q) || act_v_q || fifo_cnt_q != '0);

  always_comb begin
    task_cnt_d = task_cnt_q; fifo_cnt_d = fifo_cnt_q;
    head_d = head_q; tail_d = tail_q; act_d = act_q; act_v_d = act_v_q;
    slice_d = slice_q; time_d = time_q; sw_d = sw_q; sum_d = sum_q;
    lend_d = lend_q; scan_d = scan_q; done_v_d = done_v_q; done_i_d = done_i_q;
    slot_d = slot_q;
    arr_we = 1'b0; arr_wa = task_cnt_q[IW-1:0]; arr_wd = arrival_i;
    rem_we = 1'b0; rem_wa = task_cnt_q[IW-1:0]; rem_wd = duration_i;
    fifo_we = 1'b0; fifo_wa = tail_q; fifo_wd = act_q;
    arr_ra = act_q; rem_ra = act_q; fifo_ra = head_q;
    case (ctrl_i.cmd)
      CmdLoad: begin
        if (task_cnt_q < CntMax) begin
          arr_we = 1'b1; rem_we = 1'b1;
          task_cnt_d = task_cnt_q + 1'b1;
          if (end_sum > lend_q) lend_d = end_sum;
        end
      end
      // rem_rd/arr_rd of the active task are valid here
      CmdHead: begin
        done_v_d = 1'b0; done_i_d = '0; scan_d = '0;
        slot_d = time_q;
        if (act_v_q) begin
          if (rem_rd == '0) begin
            sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
            done_v_d = 1'b1; done_i_d = act_q;
            act_v_d = 1'b0; slice_d = '0;
          end else if (slice_q >= q_eff) begin
            if (push_ok) begin
              fifo_we = 1'b1; fifo_wd = act_q;
              tail_d = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
              fifo_cnt_d = fifo_cnt_q + 1'b1;
            end
            act_v_d = 1'b0; slice_d = '0;
            if (sw_q != TimeMax) sw_d = sw_q + 1'b1;
          end
        end
      end
      CmdScanRd: begin
        arr_ra = scan_q;
      end
      CmdScanCmp: begin
        if (arr_rd == time_q[ValW-1:0] && time_q[TimeW-1:ValW] == '0 && push_ok) begin
          fifo_we = 1'b1; fifo_wd = cmp_idx_q;
          tail_d = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
          fifo_cnt_d = fifo_cnt_q + 1'b1;
        end
        scan_d = scan_q + 1'b1;
        arr_ra = scan_d;
      end
      CmdDispatch: begin
        // fifo_rd holds the head word; the rem read for it is issued here
        if (!act_v_q && fifo_cnt_q != '0) begin
          act_d = fifo_rd; act_v_d = 1'b1; slice_d = '0;
          head_d = (head_q == IdxLast) ? '0 : head_q + 1'b1;
          fifo_cnt_d = fifo_cnt_q - 1'b1;
        end
        rem_ra = act_d;
      end
      CmdFinish: begin
        if (time_q != TimeMax) time_d = time_q + 1'b1;
        if (act_v_q) begin
          if (rem_rd != '0) begin
            rem_we = 1'b1; rem_wa = act_q; rem_wd = rem_rd - 1'b1;
          end
          if (slice_q != 8'hFF) slice_d = slice_q + 1'b1;
        end
      end
      // tick once the schedule has drained: hold the slot, show nothing completed
      CmdHold: begin
        done_v_d = 1'b0; done_i_d = '0;
        slot_d = time_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_cnt_q <= '0; fifo_cnt_q <= '0; head_q <= '0; tail_q <= '0;
      act_q <= '0; act_v_q <= 1'b0; slice_q <= '0; time_q <= '0;
      sw_q <= '0; sum_q <= '0; lend_q <= '0; scan_q <= '0;
      done_v_q <= 1'b0; done_i_q <= '0; cmp_idx_q <= '0; slot_q <= '0;
    end else begin
      task_cnt_q <= task_cnt_d; fifo_cnt_q <= fifo_cnt_d; head_q <= head_d;
      tail_q <= tail_d; act_q <= act_d; act_v_q <= act_v_d; slice_q <= slice_d;
      time_q <= time_d; sw_q <= sw_d; sum_q <= sum_d; lend_q <= lend_d;
      scan_q <= scan_d; done_v_q <= done_v_d; done_i_q <= done_i_d;
      slot_q <= slot_d;
      cmp_idx_q <= (ctrl_i.cmd == CmdScanCmp) ? scan_d : scan_q;
    end
  end

  assign stat_o.finished  = fin;
  assign stat_o.scan_last = ({1'b0, scan_q} + 1'b1 >= {1'b0, task_cnt_q});
  assign stat_o.load_full = (task_cnt_q == CntMax);

  assign slot_time_o        = slot_q;
  assign running_valid_o    = act_v_q;
  assign running_index_o    = act_v_q ? IdxOutW'(act_q) : '0;
  assign completed_valid_o  = done_v_q;
  assign completed_index_o  = done_v_q ? IdxOutW'(done_i_q) : '0;
  assign switch_count_o     = sw_q;
  assign total_turnaround_o = sum_q;

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_fifo_bound, clk_i, rst_ni, fifo_cnt_q > CntMax)
  `ASSERT_NEVER(a_task_bound, clk_i, rst_ni, task_cnt_q > CntMax)
  `ASSERT_IMPL(a_time_mono, clk_i, rst_ni, $past(time_q) <= time_q)
endmodule

// ----- sv/rrts_ctrl.sv -----
// Sequencer of the scheduler: steps the datapath through one item.
// Depends on rrts_pkg and assert_macros.svh.
module rrts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            finished_o,
  output rrts_pkg::ctrl_t ctrl_o,
  input  rrts_pkg::stat_t stat_i
);
  import rrts_pkg::*;
  typedef enum logic [3:0] {
    StIdle, StRdHead, StHead, StScanRd, StScanCmp, StDispRd, StDisp, StRdRem, StFinish,
    StOut
  } state_e;

  state_e st_q;
  logic out_v_q, fin_q;

  assign in_ready_o  = (st_q == StIdle) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign finished_o  = fin_q;

  always_comb begin
    ctrl_o.cmd = CmdNone;
    ctrl_o.scan_first = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          if (func_i == FuncLoad) ctrl_o.cmd = CmdLoad;
          else if (stat_i.finished) ctrl_o.cmd = CmdHold;
        end
      end
      StHead:    ctrl_o.cmd = CmdHead;
      StScanRd:  begin ctrl_o.cmd = CmdScanRd; ctrl_o.scan_first = 1'b1; end
      StScanCmp: ctrl_o.cmd = CmdScanCmp;
      StDisp:    ctrl_o.cmd = CmdDispatch;
      StFinish:  ctrl_o.cmd = CmdFinish;
      default:   ctrl_o.cmd = CmdNone;
    endcase
  end

  // the scan issues the next address while comparing the previous word
  logic [0:0] unused_first;
  assign unused_first = ctrl_o.scan_first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; out_v_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (st_q)
        StIdle: if (in_valid_i && in_ready_o && func_i == FuncTick) begin
          if (stat_i.finished) begin
            fin_q <= 1'b1; st_q <= StOut;
          end else begin
            st_q <= StRdHead;
          end
        end
        StRdHead:  st_q <= StHead;
        StHead:    st_q <= StScanRd;
        StScanRd:  st_q <= StScanCmp;
        StScanCmp: if (stat_i.scan_last || !stat_i.load_full && 1'b0) st_q <= StDispRd;
        StDispRd:  st_q <= StDisp;
        StDisp:    st_q <= StRdRem;
        StRdRem:   st_q <= StFinish;
        StFinish:  begin st_q <= StOut; fin_q <= 1'b0; end
        StOut: begin
          out_v_q <= 1'b1; st_q <= StIdle;
          if (!fin_q) fin_q <= stat_i.finished;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_take_busy, clk_i, rst_ni, in_ready_o && st_q != StIdle)
  `ASSERT_IMPL(a_out_idle, clk_i, rst_ni, $rose(out_v_q) |-> st_q == StIdle)
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_v_q && !out_ready_i |=> out_v_q)
endmodule

// ----- sv/round_robin_tick_scheduler_unit.sv -----
// Round-robin tick scheduler with configurable quantum. A load word (func 0) adds a
// task; a tick word (func 1) runs one slot and returns one result word. A load is
// written to the task tables as it is accepted; the length of a tick is set by the
// scan of the arrival table at one word per cycle; no new word is accepted until the
// result is taken. A tick after the schedule drains skips the scan. No clearing pass.
// Depends on rrts_pkg, rrts_ctrl, rrts_datapath.
module round_robin_tick_scheduler_unit #(
  parameter int unsigned MaxTasks = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // arrival[15:0], duration[31:16]
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_time, running_valid, running_index, completed_valid, completed_index,
  // switch_count, total_turnaround, finished (from bit 0 up)
  output logic [95:0] m_axis_tdata
);
  import rrts_pkg::*;
  logic [7:0] quantum_q;
  ctrl_t ctrl;
  stat_t stat;
  logic fin;
  logic [22:0] slot, swc;
  logic rv, cv;
  logic [5:0] ri, ci;
  logic [28:0] tat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quantum_q <= QuantumReset;
    else if (cfg_we_i) quantum_q <= cfg_wdata_i;
  end

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .func_i(s_axis_tuser), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .finished_o(fin), .ctrl_o(ctrl), .stat_i(stat));

  rrts_datapath #(.MaxTasks(MaxTasks)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .arrival_i(s_axis_tdata[15:0]), .duration_i(s_axis_tdata[31:16]),
    .quantum_i(quantum_q), .slot_time_o(slot), .running_valid_o(rv),
    .running_index_o(ri), .completed_valid_o(cv), .completed_index_o(ci),
    .switch_count_o(swc), .total_turnaround_o(tat));

  assign m_axis_tdata = {6'd0, fin, tat, swc, ci, cv, ri, rv, slot};
endmodule
